@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the row ghost reduction block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/lgr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row ghost reduction package
// Sizes, types and codes shared by the window cells, the tap units and the
// top level.
// ----------------------------------------------------------------------------
package lgr_pkg;

   // Design sizes.
   localparam int NUM_TAPS   = 4;
   localparam int MAX_SHIFT  = 32;
   localparam int PIXEL_BITS = 16;
   localparam int MAX_WIDTH  = 4096;

   // Port field widths.
   localparam int OUT_W   = 16;
   localparam int IN_W    = 16;
   localparam int TAP_W   = 24;
   localparam int LW_W    = 13;
   localparam int PEAK_W  = 16;
   localparam int DATA_W  = 32;

   // Window: stored cells plus the incoming sample form the visible window.
   localparam int LINE_CELLS = 2 * MAX_SHIFT;
   localparam int WIN_CELLS  = LINE_CELLS + 1;
   localparam int SEL_W      = $clog2(WIN_CELLS);

   // Column and bound widths.
   localparam int COL_W   = LW_W;
   localparam int X_W     = $clog2(MAX_WIDTH);
   localparam int BOUND_W = LW_W + 1;
   localparam int SH_W    = 9;

   // Arithmetic widths.
   localparam int INTEN_W   = 8;
   localparam int TERM_W    = PIXEL_BITS + 1;
   localparam int PROD_W    = TERM_W + INTEN_W;
   localparam int SUM_W     = PROD_W + $clog2(NUM_TAPS);
   localparam int ADJ_SHIFT = 7;
   localparam int ADJ_W     = SUM_W - ADJ_SHIFT;
   localparam int V_W       = ((ADJ_W > OUT_W) ? ADJ_W : OUT_W) + 1;

   // Register map.
   localparam int NUM_REGS       = NUM_TAPS + 2;
   localparam int REG_LINE_WIDTH = NUM_TAPS;
   localparam int REG_PEAK       = NUM_TAPS + 1;
   localparam int ADDR_W         = $clog2(4 * NUM_REGS);
   localparam int IDX_W          = ADDR_W - 2;

   // Reset values of the configuration registers.
   localparam logic [LW_W-1:0]   LINE_WIDTH_RESET = LW_W'(1920);
   localparam logic [PEAK_W-1:0] PEAK_RESET       = PEAK_W'(255);

   // Tap mode codes.
   typedef enum logic [2:0] {
      MODE_OFF     = 3'd0,
      MODE_EDGE    = 3'd1,
      MODE_LEVEL   = 3'd2,
      MODE_RISING  = 3'd3,
      MODE_FALLING = 3'd4
   } mode_type;

   typedef logic [PIXEL_BITS-1:0] pix_type;
   typedef logic [WIN_CELLS-1:0][PIXEL_BITS-1:0] win_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // Contents of one window cell.
   typedef struct packed {
      logic    valid;
      logic    last;
      pix_type pixel;
   } cell_type;

   // Pipeline control handed to each tap unit.
   typedef struct packed {
      logic load;
      logic adv;
   } tap_ctl_type;

endpackage

@@ src/luma_ghost_reduction_row.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row ghost reduction for luma samples
// Corrects each pixel of a row by the weighted sum of up to NUM_TAPS shifted
// edge or level terms and clamps the result to 0..peak.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Transaction
//   req       in          one source pixel of the row (req_pixel_in)
//   rsp       out         one corrected pixel (rsp_pixel_out, rsp_row_end)
//   csr       in/out      APB register write or read
//
// One pixel is taken per clock while req_stall is low; its result leaves
// MAX_SHIFT pixels later through tap select, multiply, sum and clamp.
// After the last pixel of a row the window drains while req_stall is high,
// until that pixel leaves the center cell; the next row starts after that.
// Reset is synchronous: it empties the window and the pipeline and loads the
// register defaults.
// A stalled result is held in the output register and one more in a skid
// stage; once the skid is full req_stall rises, as it does during a drain.
// ----------------------------------------------------------------------------
module luma_ghost_reduction_row
   import lgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Pixel input
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [IN_W-1:0]   req_pixel_in,
   // Corrected pixel output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [OUT_W-1:0]  rsp_pixel_out,
   output logic              rsp_row_end,
   // Register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [TAP_W-1:0]  tap_ff [NUM_TAPS];
   logic [LW_W-1:0]   line_width_ff;
   logic [PEAK_W-1:0] peak_ff;
   logic [IDX_W-1:0]  csr_idx;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TAPS; t++) begin
            tap_ff[t] <= '0;
         end
         line_width_ff <= LINE_WIDTH_RESET;
         peak_ff       <= PEAK_RESET;
      end else if (csr_wr) begin
         for (int t = 0; t < NUM_TAPS; t++) begin
            if (csr_idx == IDX_W'(t)) begin
               tap_ff[t] <= csr_pwdata[TAP_W-1:0];
            end
         end
         if (csr_idx == IDX_W'(REG_LINE_WIDTH)) begin
            line_width_ff <= csr_pwdata[LW_W-1:0];
         end
         if (csr_idx == IDX_W'(REG_PEAK)) begin
            peak_ff <= csr_pwdata[PEAK_W-1:0];
         end
      end
   end

   // Register reads.
   always_comb begin
      csr_prdata = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
         if (csr_idx == IDX_W'(t)) begin
            csr_prdata = DATA_W'(tap_ff[t]);
         end
      end
      if (csr_idx == IDX_W'(REG_LINE_WIDTH)) begin
         csr_prdata = DATA_W'(line_width_ff);
      end
      if (csr_idx == IDX_W'(REG_PEAK)) begin
         csr_prdata = DATA_W'(peak_ff);
      end
   end

   // Line width limited to 1..MAX_WIDTH.
   logic [LW_W-1:0] width_eff;

   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = LW_W'(1);
      end else if (line_width_ff > LW_W'(MAX_WIDTH)) begin
         width_eff = LW_W'(MAX_WIDTH);
      end else begin
         width_eff = line_width_ff;
      end
   end

   // ------------------------------------------------------------------
   // Flow control
   // ------------------------------------------------------------------
   logic             skid_valid_ff;
   logic             out_valid_ff;
   logic             pipe_en;
   logic             flush_ff;
   logic             req_accept;
   logic             line_adv;
   logic [COL_W-1:0] col_in_ff;
   logic [COL_W-1:0] col_in_inc;
   logic             row_done;

   assign pipe_en    = !skid_valid_ff;
   assign req_stall  = flush_ff || skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign line_adv   = pipe_en && (req_accept || flush_ff);
   assign col_in_inc = col_in_ff + COL_W'(1);
   assign row_done   = (col_in_inc >= width_eff);

   // ------------------------------------------------------------------
   // Window chain
   // ------------------------------------------------------------------
   cell_type cell_q [LINE_CELLS];
   cell_type head;
   win_type  win_pix;
   cell_type center;

   // During a drain a bubble enters in place of a pixel.
   assign head = '{valid: !flush_ff,
                   last:  !flush_ff && row_done,
                   pixel: req_pixel_in[PIXEL_BITS-1:0]};

   for (genvar k = 0; k < LINE_CELLS; k++) begin : g_cell
      lgr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (line_adv),
         .cell_d   ((k == 0) ? head : cell_q[(k == 0) ? 0 : k - 1]),
         .cell_q   (cell_q[k])
      );
   end

   // The window as it stands after this shift; the output column is centered.
   always_comb begin
      win_pix[0] = head.pixel;
      for (int k = 1; k < WIN_CELLS; k++) begin
         win_pix[k] = cell_q[k-1].pixel;
      end
   end

   assign center = cell_q[MAX_SHIFT-1];

   // Input column, drain flag and output column.
   logic [X_W-1:0] col_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_in_ff  <= '0;
         col_out_ff <= '0;
         flush_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            col_in_ff <= row_done ? '0 : col_in_inc;
            if (row_done) begin
               flush_ff <= 1'b1;
            end
         end
         if (line_adv && center.valid) begin
            col_out_ff <= center.last ? '0 : col_out_ff + X_W'(1);
            if (center.last) begin
               flush_ff <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tap units
   // ------------------------------------------------------------------
   tap_ctl_type tap_ctl;
   prod_type    prod [NUM_TAPS];

   assign tap_ctl = '{load: line_adv, adv: pipe_en};

   for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
      lgr_tap u_tap (
         .clock     (clock),
         .tap_word  (tap_ff[t]),
         .width_eff (width_eff),
         .win       (win_pix),
         .x_col     (col_out_ff),
         .ctl       (tap_ctl),
         .prod      (prod[t])
      );
   end

   // ------------------------------------------------------------------
   // Correction pipeline: term, product, sum, clamp
   // ------------------------------------------------------------------
   logic                    a_valid_ff, b_valid_ff, c_valid_ff;
   logic                    a_last_ff, b_last_ff, c_last_ff;
   pix_type                 a_pix_ff, b_pix_ff, c_pix_ff;
   logic signed [SUM_W-1:0] sum;
   logic signed [ADJ_W-1:0] adj_in, c_adj_ff;

   // Tap sum, floored by 128.
   always_comb begin
      sum = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
         sum = sum + SUM_W'(prod[t]);
      end
      adj_in = $signed(sum[SUM_W-1:ADJ_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         a_valid_ff <= line_adv && center.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (line_adv) begin
         a_pix_ff  <= center.pixel;
         a_last_ff <= center.last;
      end
      if (pipe_en) begin
         b_pix_ff  <= a_pix_ff;
         b_last_ff <= a_last_ff;
         c_pix_ff  <= b_pix_ff;
         c_last_ff <= b_last_ff;
         c_adj_ff  <= adj_in;
      end
   end

   // Corrected value, clamped to 0..peak.
   logic signed [V_W-1:0] v_sum;
   logic [OUT_W-1:0]      res_pixel;

   always_comb begin
      v_sum = $signed({{(V_W-PIXEL_BITS){1'b0}}, c_pix_ff})
              + $signed({{(V_W-ADJ_W){c_adj_ff[ADJ_W-1]}}, c_adj_ff});
      if (v_sum[V_W-1]) begin
         res_pixel = '0;
      end else if (v_sum > $signed({{(V_W-PEAK_W){1'b0}}, peak_ff})) begin
         res_pixel = OUT_W'(peak_ff);
      end else begin
         res_pixel = v_sum[OUT_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Output register and skid stage
   // ------------------------------------------------------------------
   logic             out_take;
   logic [OUT_W-1:0] out_pixel_ff, skid_pixel_ff;
   logic             out_last_ff, skid_last_ff;
   logic             out_load;
   logic             skid_load;

   assign out_take  = out_valid_ff && !rsp_stall;
   assign out_load  = pipe_en && (!out_valid_ff || out_take);
   assign skid_load = pipe_en && c_valid_ff && out_valid_ff && !out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (out_load) begin
         out_valid_ff <= c_valid_ff;
      end else if (skid_load) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && out_take) begin
         out_pixel_ff <= skid_pixel_ff;
         out_last_ff  <= skid_last_ff;
      end else if (out_load) begin
         out_pixel_ff <= res_pixel;
         out_last_ff  <= c_last_ff;
      end
      if (skid_load) begin
         skid_pixel_ff <= res_pixel;
         skid_last_ff  <= c_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_row_end   = out_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid holds a result while the output register is empty")
   `ASSERT_NEXT(a_row_end_drains, clock, reset, req_accept && row_done, flush_ff && (col_in_ff == '0), "row end did not start the window drain")
   `ASSERT_IMPLIES(a_drain_col_clear, clock, reset, flush_ff, col_in_ff == '0, "input column moved during the window drain")

endmodule

@@ src/lgr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window cell
// One sample of the row window. On each shift the cell takes the contents of
// its upstream neighbor and hands its own to the downstream one.
// ----------------------------------------------------------------------------
module lgr_cell
   import lgr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  cell_type cell_d,
   output cell_type cell_q
);

   logic    valid_ff;
   logic    last_ff;
   pix_type pixel_ff;

   // Flags mark real samples of the current row and the row's final sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= cell_d.valid;
         last_ff  <= cell_d.last;
      end
   end

   // The sample itself needs no reset.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         pixel_ff <= cell_d.pixel;
      end
   end

   assign cell_q = '{valid: valid_ff, last: last_ff, pixel: pixel_ff};

endmodule

@@ src/lgr_tap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap unit
// Decodes one tap word, selects its term from the window at the output
// column and multiplies it by the tap intensity over two stages.
// ----------------------------------------------------------------------------
module lgr_tap
   import lgr_pkg::*;
(
   input  logic              clock,
   input  logic [TAP_W-1:0]  tap_word,
   input  logic [LW_W-1:0]   width_eff,
   input  win_type           win,
   input  logic [X_W-1:0]    x_col,
   input  tap_ctl_type       ctl,
   output prod_type          prod
);

   // Decoded tap setup, refreshed every cycle from the register.
   logic                      ok_in, ok_ff;
   mode_type                  mode_in, mode_ff;
   logic signed [INTEN_W-1:0] inten_ff;
   logic signed [BOUND_W-1:0] lo_in, lo_ff, hi_in, hi_ff;
   logic [SEL_W-1:0]          sel_a_in, sel_a_ff, sel_b_in, sel_b_ff;

   logic signed [SH_W-1:0]    sh;
   logic [SH_W-1:0]           mag;
   logic                      edge_mode;
   logic                      neg_adj;
   logic signed [SH_W-1:0]    s_adj;
   logic signed [BOUND_W-1:0] w_adj;
   logic signed [BOUND_W-1:0] s_ext;
   logic signed [SH_W-1:0]    sel_wide;

   always_comb begin
      sh        = SH_W'($signed(tap_word[23:16]));
      mag       = sh[SH_W-1] ? SH_W'(-sh) : SH_W'(sh);
      case (mode_type'(tap_word[2:0]))
         MODE_EDGE:    mode_in = MODE_EDGE;
         MODE_LEVEL:   mode_in = MODE_LEVEL;
         MODE_RISING:  mode_in = MODE_RISING;
         MODE_FALLING: mode_in = MODE_FALLING;
         default:      mode_in = MODE_OFF;
      endcase
      edge_mode = (mode_in != MODE_LEVEL);
      ok_in     = (mode_in != MODE_OFF)
                  && (mag <= SH_W'(MAX_SHIFT))
                  && (LW_W'(mag) < width_eff)
                  && !(edge_mode && (sh == '0));
      // Edge taps with a negative shift move one column and lose a column.
      neg_adj  = edge_mode && sh[SH_W-1];
      s_adj    = sh + $signed(SH_W'(neg_adj));
      w_adj    = $signed({1'b0, width_eff}) - $signed(BOUND_W'(neg_adj));
      s_ext    = BOUND_W'(s_adj);
      lo_in    = (s_adj > 0) ? s_ext : '0;
      hi_in    = (s_adj < 0) ? (w_adj + s_ext) : w_adj;
      sel_wide = $signed(SH_W'(MAX_SHIFT)) + s_adj;
      sel_a_in = ok_in ? sel_wide[SEL_W-1:0] : '0;
      sel_b_in = (ok_in && (sel_wide != '0)) ? SEL_W'(sel_wide - 1) : '0;
   end

   always_ff @(posedge clock) begin
      ok_ff    <= ok_in;
      mode_ff  <= mode_in;
      inten_ff <= $signed(tap_word[15:8]);
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      sel_a_ff <= sel_a_in;
      sel_b_ff <= sel_b_in;
   end

   // Term selection at the output column.
   logic signed [TERM_W-1:0]  level;
   logic signed [TERM_W-1:0]  diff;
   logic signed [BOUND_W-1:0] x_s;
   logic                      in_range;
   logic signed [TERM_W-1:0]  term_in, term_ff;
   prod_type                  prod_ff;

   always_comb begin
      level    = $signed({1'b0, win[sel_a_ff]});
      diff     = $signed({1'b0, win[sel_b_ff]}) - level;
      x_s      = $signed({{(BOUND_W-X_W){1'b0}}, x_col});
      in_range = ok_ff && (x_s >= lo_ff) && (x_s < hi_ff);
      term_in  = '0;
      if (in_range) begin
         case (mode_ff)
            MODE_EDGE:    term_in = diff;
            MODE_LEVEL:   term_in = level;
            MODE_RISING:  term_in = (diff > 0) ? diff : '0;
            MODE_FALLING: term_in = (diff < 0) ? diff : '0;
            default:      term_in = '0;
         endcase
      end
   end

   // Stage one holds the term, stage two the weighted term.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         term_ff <= term_in;
      end
      if (ctl.adv) begin
         prod_ff <= term_ff * inten_ff;
      end
   end

   assign prod = prod_ff;

endmodule
